@@ sv/rfla_pkg.sv @@
// Shared constants, types and helpers of the row flow layout aligner.
package rfla_pkg;

  // Row buffer depth and derived widths
  localparam int ROW_SLOTS = 32;
  localparam int SLOT_W    = $clog2(ROW_SLOTS);
  localparam int CNT_W     = $clog2(ROW_SLOTS + 1);

  // Field widths
  localparam int DIM_W   = 10;
  localparam int HALF_W  = DIM_W - 1;
  localparam int POS_W   = 16;
  localparam int SUM_W   = POS_W + 1;
  localparam int SP_W    = 8;
  localparam int SCR_W   = 12;
  localparam int PCT_W   = 8;
  localparam int COLT_W  = 6;
  localparam int ALIGN_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PCT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TGT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_MODE  = 3'd5;

  localparam logic [SP_W-1:0] SPACING_RST = 8'd8;

  // Vertical alignment codes; any other code aligns to the top
  localparam logic [ALIGN_W-1:0] ALIGN_MIDDLE = 2'd1;
  localparam logic [ALIGN_W-1:0] ALIGN_BOTTOM = 2'd2;

  // Usable width: screen * pct / 100 by a reciprocal multiply
  localparam logic [SCR_W-1:0] DEFAULT_SCREEN = 12'd640;
  localparam int PCT_FULL    = 100;
  localparam int PROD_W      = SCR_W + PCT_W;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_K =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PCT_FULL) - 64'd1) / 64'(PCT_FULL));

  // One buffered box
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [DIM_W-1:0] h;
  } slot_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic prep;
    logic emit_start;
    logic out_load;
    logic run_end;
    logic close;
    logic place;
    logic final_clear;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic flush;
    logic row_empty;
    logic emit_last;
    logic fin;
    logic out_free;
  } dp_sts_t;

  function automatic logic [POS_W-1:0] sat16(input logic [SUM_W-1:0] v);
    return v[POS_W] ? {POS_W{1'b1}} : v[POS_W-1:0];
  endfunction

endpackage

@@ sv/rfla_box_if.sv @@
// Input channel carrying one box word.
interface rfla_box_if;
  logic                       valid;
  logic                       ready;
  logic [rfla_pkg::DIM_W-1:0] full_width;
  logic [rfla_pkg::DIM_W-1:0] full_height;
  logic [rfla_pkg::DIM_W-1:0] image_width;
  logic [rfla_pkg::DIM_W-1:0] label_width;
  logic                       final_box;

  modport source (
    output valid, full_width, full_height, image_width, label_width, final_box,
    input  ready
  );
  modport sink (
    input  valid, full_width, full_height, image_width, label_width, final_box,
    output ready
  );
endinterface

@@ sv/rfla_place_if.sv @@
// Output channel carrying one placed-box word.
interface rfla_place_if;
  logic                       valid;
  logic                       ready;
  logic [rfla_pkg::POS_W-1:0] pos_x;
  logic [rfla_pkg::POS_W-1:0] pos_y;
  logic                       row_end;
  logic                       run_end;

  modport source (
    output valid, pos_x, pos_y, row_end, run_end,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, row_end, run_end,
    output ready
  );
endinterface

@@ sv/rfla_datapath.sv @@
// Datapath: config registers, cursor and row state, row buffer, output register.
module rfla_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rfla_pkg::dp_cmd_t                   cmd_i,
  output rfla_pkg::dp_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [rfla_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rfla_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [rfla_pkg::DIM_W-1:0]          full_width_i,
  input  logic [rfla_pkg::DIM_W-1:0]          full_height_i,
  input  logic [rfla_pkg::DIM_W-1:0]          image_width_i,
  input  logic [rfla_pkg::DIM_W-1:0]          label_width_i,
  input  logic                                final_box_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [rfla_pkg::POS_W-1:0]          pos_x_o,
  output logic [rfla_pkg::POS_W-1:0]          pos_y_o,
  output logic                                row_end_o,
  output logic                                run_end_o
);
  import rfla_pkg::*;

  // Configuration
  logic [SP_W-1:0]    spacing_x_q, spacing_y_q;
  logic [SCR_W-1:0]   screen_q;
  logic [PCT_W-1:0]   pct_q;
  logic [COLT_W-1:0]  col_tgt_q;
  logic [ALIGN_W-1:0] align_q;

  // Usable width pipeline
  logic [SCR_W-1:0]          screen_eff;
  logic                      pct_ok;
  logic [PROD_W-1:0]         prod_q;
  logic                      scale_q;
  logic [SCR_W-1:0]          base_q;
  logic [PROD_W+RECIP_W-1:0] scaled;
  logic [SCR_W-1:0]          usable_q;

  // Current box
  logic [DIM_W-1:0]  fw_q, fh_q, iw_q, lw_q;
  logic              fin_q;
  logic [DIM_W-1:0]  lbl_diff;
  logic [HALF_W-1:0] off_q;
  logic [SUM_W-1:0]  cur_sum_q;

  // Row state
  logic [POS_W-1:0] cursor_q, cursor_d;
  logic [POS_W-1:0] row_top_q, row_top_d;
  logic [DIM_W-1:0] tallest_q, tallest_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             list_start_q, list_start_d;
  logic [CNT_W-1:0] emit_k_q, emit_k_d;
  logic             wrap;

  // Row buffer
  slot_t mem [ROW_SLOTS];
  slot_t rd_q;
  slot_t wr_slot;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] pos_x_q, pos_y_q;
  logic             row_end_q, run_end_q;
  logic [DIM_W-1:0] gap, align_off;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_x_q <= SPACING_RST;
      spacing_y_q <= SPACING_RST;
      screen_q    <= '0;
      pct_q       <= '0;
      col_tgt_q   <= '0;
      align_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPACING_X:  spacing_x_q <= cfg_wdata_i[SP_W-1:0];
        CFG_SPACING_Y:  spacing_y_q <= cfg_wdata_i[SP_W-1:0];
        CFG_SCREEN_W:   screen_q    <= cfg_wdata_i[SCR_W-1:0];
        CFG_WIDTH_PCT:  pct_q       <= cfg_wdata_i[PCT_W-1:0];
        CFG_COLUMN_TGT: col_tgt_q   <= cfg_wdata_i[COLT_W-1:0];
        CFG_ALIGN_MODE: align_q     <= cfg_wdata_i[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Usable width, two stages: product, then divide by 100 via reciprocal
  assign screen_eff = (screen_q == '0) ? DEFAULT_SCREEN : screen_q;
  assign pct_ok     = (pct_q != '0) && (pct_q < PCT_W'(PCT_FULL));
  assign scaled     = prod_q * RECIP_K;

  always_ff @(posedge clk_i) begin
    prod_q   <= screen_eff * pct_q;
    scale_q  <= pct_ok;
    base_q   <= screen_eff;
    usable_q <= scale_q ? scaled[RECIP_SHIFT +: SCR_W] : base_q;
  end

  // Box capture and per-box precompute
  assign lbl_diff = lw_q - iw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      fw_q  <= full_width_i;
      fh_q  <= full_height_i;
      iw_q  <= image_width_i;
      lw_q  <= label_width_i;
      fin_q <= final_box_i;
    end
    if (cmd_i.prep) begin
      off_q     <= (lw_q > iw_q) ? lbl_diff[DIM_W-1:1] : '0;
      cur_sum_q <= {1'b0, cursor_q} + SUM_W'(fw_q) + SUM_W'(spacing_x_q)
                   + SUM_W'(spacing_x_q);
    end
  end

  // Wrap decision
  always_comb begin
    if (col_tgt_q != '0) begin
      wrap = COLT_W'(count_q) >= col_tgt_q;
    end else begin
      wrap = cur_sum_q > SUM_W'(usable_q);
    end
  end

  assign sts_o.flush     = (count_q >= CNT_W'(ROW_SLOTS))
                           || ((cursor_q > POS_W'(spacing_x_q)) && wrap);
  assign sts_o.row_empty = (count_q == '0);
  assign sts_o.emit_last = ((emit_k_q + CNT_W'(1)) == count_q);
  assign sts_o.fin       = fin_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Row state update
  always_comb begin
    cursor_d     = cursor_q;
    row_top_d    = row_top_q;
    tallest_d    = tallest_q;
    count_d      = count_q;
    list_start_d = list_start_q;
    emit_k_d     = emit_k_q;
    if (cmd_i.accept && list_start_q) begin
      cursor_d     = POS_W'(spacing_x_q);
      row_top_d    = POS_W'(spacing_y_q);
      tallest_d    = '0;
      count_d      = '0;
      list_start_d = 1'b0;
    end
    if (cmd_i.close) begin
      cursor_d  = POS_W'(spacing_x_q);
      row_top_d = sat16({1'b0, row_top_q} + SUM_W'(tallest_q) + SUM_W'(spacing_y_q));
      tallest_d = '0;
      count_d   = '0;
    end
    if (cmd_i.place) begin
      count_d   = count_q + CNT_W'(1);
      tallest_d = (fh_q > tallest_q) ? fh_q : tallest_q;
      cursor_d  = sat16({1'b0, cursor_q} + SUM_W'(fw_q) + SUM_W'(spacing_x_q));
    end
    if (cmd_i.final_clear) begin
      tallest_d    = '0;
      count_d      = '0;
      list_start_d = 1'b1;
    end
    if (cmd_i.emit_start) begin
      emit_k_d = '0;
    end else if (cmd_i.out_load && !sts_o.emit_last) begin
      emit_k_d = emit_k_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q     <= POS_W'(SPACING_RST);
      row_top_q    <= POS_W'(SPACING_RST);
      tallest_q    <= '0;
      count_q      <= '0;
      list_start_q <= 1'b1;
      emit_k_q     <= '0;
    end else begin
      cursor_q     <= cursor_d;
      row_top_q    <= row_top_d;
      tallest_q    <= tallest_d;
      count_q      <= count_d;
      list_start_q <= list_start_d;
      emit_k_q     <= emit_k_d;
    end
  end

  // Row buffer: write on place, registered read at the emit index
  assign wr_slot.x = sat16({1'b0, cursor_q} + SUM_W'(off_q));
  assign wr_slot.h = fh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      mem[count_q[SLOT_W-1:0]] <= wr_slot;
    end
    rd_q <= mem[emit_k_q[SLOT_W-1:0]];
  end

  // Alignment offset against the tallest box of the row
  always_comb begin
    gap = (tallest_q > rd_q.h) ? (tallest_q - rd_q.h) : '0;
    case (align_q)
      ALIGN_MIDDLE: align_off = {1'b0, gap[DIM_W-1:1]};
      ALIGN_BOTTOM: align_off = gap;
      default:      align_off = '0;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pos_x_q   <= rd_q.x;
      pos_y_q   <= sat16({1'b0, row_top_q} + SUM_W'(align_off));
      row_end_q <= sts_o.emit_last;
      run_end_q <= cmd_i.run_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign row_end_o   = row_end_q;
  assign run_end_o   = run_end_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ROW_SLOTS))
    else $error("row count beyond buffer depth");

  a_place_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |-> (count_q < CNT_W'(ROW_SLOTS)))
    else $error("box placed into a full row buffer");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before taken");

  a_final_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.final_clear |=> (list_start_q && (count_q == '0)))
    else $error("list not restarted after final row");
`endif

endmodule

@@ sv/rfla_ctrl.sv @@
// Controller: sequences accept, wrap decision, row emission and placement.
module rfla_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rfla_pkg::dp_sts_t sts_i,
  output rfla_pkg::dp_cmd_t cmd_o
);
  import rfla_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_RD     = 7'b0001000,
    S_OUT    = 7'b0010000,
    S_CLOSE  = 7'b0100000,
    S_PLACE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   final_pass_q, final_pass_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    final_pass_d = final_pass_q;
    cmd_o        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.flush) begin
          state_d = S_PLACE;
        end else if (sts_i.row_empty) begin
          state_d = S_CLOSE;
        end else begin
          cmd_o.emit_start = 1'b1;
          final_pass_d     = 1'b0;
          state_d          = S_RD;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.run_end  = sts_i.emit_last && (final_pass_q || !sts_i.fin);
          if (!sts_i.emit_last) begin
            state_d = S_RD;
          end else if (final_pass_q) begin
            cmd_o.final_clear = 1'b1;
            state_d           = S_IDLE;
          end else begin
            state_d = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        cmd_o.close = 1'b1;
        state_d     = S_PLACE;
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        if (sts_i.fin) begin
          cmd_o.emit_start = 1'b1;
          final_pass_d     = 1'b1;
          state_d          = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      final_pass_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      final_pass_q <= final_pass_d;
    end
  end

`ifndef SYNTHESIS
  // A final placement fills the row in the same cycle, so only a flush is checked
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_start && !cmd_o.place) |-> !sts_i.row_empty)
    else $error("emission started on an empty row");

  a_final_after_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.place && sts_i.fin) |=> (state_q == S_RD && final_pass_q))
    else $error("final box did not start final row emission");

  a_rd_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |=> (state_q == S_OUT))
    else $error("buffer read not followed by output stage");
`endif

endmodule

@@ sv/row_flow_layout_aligner_unit.sv @@
// Top level of the row flow layout aligner: controller plus datapath.
//
//   channel   dir  handshake      word
//   box_i     in   valid/ready    full_width, full_height, image_width, label_width, final_box
//   place_o   out  valid/ready    pos_x, pos_y, row_end, run_end
//   cfg       in   cfg_we_i       cfg_idx_i selects register, cfg_wdata_i holds value
//
// A box that closes no row passes from accept through prep and decide to placement.
// Each emitted box takes a registered row buffer read, then an output load;
// a row close comes before placement. No clearing pass after reset.
// A stalled output holds the emission sequencer; input is taken only when idle.
module row_flow_layout_aligner_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rfla_box_if.sink                        box_i,
  rfla_place_if.source                    place_o,
  input  logic                            cfg_we_i,
  input  logic [rfla_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rfla_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import rfla_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (box_i.valid),
    .in_ready_o (box_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rfla_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .full_width_i  (box_i.full_width),
    .full_height_i (box_i.full_height),
    .image_width_i (box_i.image_width),
    .label_width_i (box_i.label_width),
    .final_box_i   (box_i.final_box),
    .out_ready_i   (place_o.ready),
    .out_valid_o   (place_o.valid),
    .pos_x_o       (place_o.pos_x),
    .pos_y_o       (place_o.pos_y),
    .row_end_o     (place_o.row_end),
    .run_end_o     (place_o.run_end)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the row flow layout aligner: directed and random boxes in, placed boxes checked.
module tb;
  import rfla_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE       = 16;

  typedef struct packed {
    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
    logic [DIM_W-1:0] iw;
    logic [DIM_W-1:0] lw;
    logic             fin;
  } box_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             row_end;
    logic             run_end;
  } place_t;

  // Box size profiles for the random lists
  typedef enum int {MIX_PLAIN, MIX_TINY, MIX_TALL} mix_e;

  typedef struct {
    int unsigned sx, sy, scr, pct, col, align;
    int          count;
    mix_e        mix;
  } phase_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  bx_valid = 1'b0;
  box_t                  bx_word  = '0;
  logic                  pl_ready = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  rfla_box_if   box_if ();
  rfla_place_if lay_if ();

  assign box_if.valid       = bx_valid;
  assign box_if.full_width  = bx_word.fw;
  assign box_if.full_height = bx_word.fh;
  assign box_if.image_width = bx_word.iw;
  assign box_if.label_width = bx_word.lw;
  assign box_if.final_box   = bx_word.fin;
  assign lay_if.ready       = pl_ready;

  row_flow_layout_aligner_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_i       (box_if),
    .place_o     (lay_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies, at reset values
  logic [SP_W-1:0]    sx      = SPACING_RST;
  logic [SP_W-1:0]    sy      = SPACING_RST;
  logic [SCR_W-1:0]   scr_w   = '0;
  logic [PCT_W-1:0]   pct     = '0;
  logic [COLT_W-1:0]  col_tgt = '0;
  logic [ALIGN_W-1:0] align   = '0;

  // Layout state
  logic [POS_W-1:0] cur_x     = SPACING_RST;
  logic [POS_W-1:0] row_top   = SPACING_RST;
  logic [DIM_W-1:0] row_tall  = '0;
  logic [CNT_W-1:0] row_cnt   = '0;
  logic             list_open = 1'b0;
  logic [POS_W-1:0] row_x [ROW_SLOTS];
  logic [DIM_W-1:0] row_h [ROW_SLOTS];

  box_t   box_q[$];
  place_t lay_q[$];
  int     pushed_cnt = 0;
  int     taken_cnt  = 0;
  int     fail_cnt   = 0;
  int     cycles     = 0;
  int     boxes_left = 0;
  bit     idle_on    = 1'b1;
  logic [3:0] gap_left   = '0;
  logic [3:0] stall_left = '0;

  function automatic logic [POS_W-1:0] clip16(input int unsigned v);
    return (v > 65535) ? 16'hFFFF : v[POS_W-1:0];
  endfunction

  // Emit the open row in order, aligned against its tallest box
  function automatic void close_row();
    int unsigned gap, dy;
    place_t      pl;
    for (int k = 0; k < row_cnt; k++) begin
      gap = (row_tall > row_h[k]) ? row_tall - row_h[k] : 0;
      if (align == ALIGN_MIDDLE) dy = gap / 2;
      else if (align == ALIGN_BOTTOM) dy = gap;
      else dy = 0;
      pl.x       = row_x[k];
      pl.y       = clip16(32'(row_top) + dy);
      pl.row_end = (k + 1 == row_cnt);
      pl.run_end = 1'b0;
      lay_q.push_back(pl);
    end
  endfunction

  // Place one accepted box and queue the boxes it releases
  function automatic void place_box(input box_t b);
    int unsigned usable, dx, n0;
    logic        wrap;
    n0 = lay_q.size();
    if (!list_open) begin
      cur_x     = sx;
      row_top   = sy;
      row_tall  = '0;
      row_cnt   = '0;
      list_open = 1'b1;
    end
    usable = (scr_w != 0) ? scr_w : 640;
    if (pct > 0 && pct < 100) usable = usable * pct / 100;
    if (col_tgt > 0) wrap = (row_cnt >= col_tgt);
    else wrap = (32'(cur_x) + b.fw + 2 * sx > usable);
    if (row_cnt >= ROW_SLOTS || (cur_x > sx && wrap)) begin
      close_row();
      cur_x    = sx;
      row_top  = clip16(32'(row_top) + row_tall + sy);
      row_tall = '0;
      row_cnt  = '0;
    end
    dx = (b.lw > b.iw) ? (b.lw - b.iw) / 2 : 0;
    if (row_cnt < ROW_SLOTS) begin
      row_x[row_cnt] = clip16(32'(cur_x) + dx);
      row_h[row_cnt] = b.fh;
      row_cnt++;
    end
    if (b.fh > row_tall) row_tall = b.fh;
    cur_x = clip16(32'(cur_x) + b.fw + sx);
    if (b.fin) begin
      close_row();
      row_tall  = '0;
      row_cnt   = '0;
      list_open = 1'b0;
    end
    if (lay_q.size() > n0) lay_q[lay_q.size() - 1].run_end = 1'b1;
  endfunction

  // Box sender: bursts of idle cycles between words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!bx_valid || box_if.ready) begin
        if (gap_left != 0 || box_q.size() == 0) begin
          bx_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 4'd1;
        end else begin
          bx_word  <= box_q.pop_front();
          bx_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) gap_left <= 4'($urandom_range(1, 14));
        end
      end
    end
  end

  // Result receiver: ready dropped in random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        pl_ready   <= 1'b0;
        stall_left <= stall_left - 4'd1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pl_ready   <= 1'b0;
        stall_left <= 4'($urandom_range(0, 13));
      end else begin
        pl_ready <= 1'b1;
      end
    end
  end

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  // Monitor: check results against the oldest expectation, predict on accept
  always @(posedge clk_i) begin
    box_t   seen;
    place_t want;
    if (rst_ni) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("%0t: timeout with %0d results pending", $time, lay_q.size());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        if (lay_if.valid && lay_if.ready) begin
          if (lay_q.size() == 0) begin
            $display("%0t: unexpected word x=%0d y=%0d row_end=%0b run_end=%0b", $time,
                     lay_if.pos_x, lay_if.pos_y, lay_if.row_end, lay_if.run_end);
            fail_cnt++;
          end else begin
            want = lay_q.pop_front();
            report("pos_x", want.x, lay_if.pos_x);
            report("pos_y", want.y, lay_if.pos_y);
            report("row_end", want.row_end, lay_if.row_end);
            report("run_end", want.run_end, lay_if.run_end);
          end
        end
        if (box_if.valid && box_if.ready) begin
          seen.fw  = box_if.full_width;
          seen.fh  = box_if.full_height;
          seen.iw  = box_if.image_width;
          seen.lw  = box_if.label_width;
          seen.fin = box_if.final_box;
          place_box(seen);
          taken_cnt++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SPACING_X:  sx      = val[SP_W-1:0];
      CFG_SPACING_Y:  sy      = val[SP_W-1:0];
      CFG_SCREEN_W:   scr_w   = val[SCR_W-1:0];
      CFG_WIDTH_PCT:  pct     = val[PCT_W-1:0];
      CFG_COLUMN_TGT: col_tgt = val[COLT_W-1:0];
      CFG_ALIGN_MODE: align   = val[ALIGN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_box(input int unsigned fw, fh, iw, lw, input bit fin);
    box_t b;
    b.fw  = DIM_W'(fw);
    b.fh  = DIM_W'(fh);
    b.iw  = DIM_W'(iw);
    b.lw  = DIM_W'(lw);
    b.fin = fin;
    box_q.push_back(b);
    pushed_cnt++;
  endtask

  // Lists of random length ending in a final box, with some noise words mixed in
  function automatic box_t make_box(input mix_e mix);
    box_t b;
    if (boxes_left == 0)
      boxes_left = (mix == MIX_PLAIN) ? $urandom_range(1, 24) : $urandom_range(60, 120);
    boxes_left--;
    b.fin = (boxes_left == 0);
    b.fh  = DIM_W'($urandom_range(0, 1023));
    b.iw  = DIM_W'($urandom_range(0, 1023));
    b.lw  = DIM_W'($urandom_range(0, 1023));
    case (mix)
      MIX_TINY: b.fw = DIM_W'($urandom_range(0, 3));
      MIX_TALL: begin
        b.fw = DIM_W'($urandom_range(0, 1023));
        b.fh = DIM_W'($urandom_range(900, 1023));
      end
      default: b.fw = DIM_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, 160));
    endcase
    if (mix == MIX_PLAIN && $urandom_range(0, 11) == 0) begin
      b.fw  = DIM_W'($urandom_range(0, 1023));
      b.fin = 1'($urandom_range(0, 1));
    end
    return b;
  endfunction

  // Wait until all boxes are taken and every expected word is out
  task automatic drain();
    while (taken_cnt != pushed_cnt || lay_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    phase_t plan[9];
    box_t   b;
    plan = '{
      '{8,   8,   0,    0,   0,  1, 40, MIX_PLAIN},
      '{255, 255, 4095, 0,   0,  2, 40, MIX_PLAIN},
      '{0,   0,   4095, 0,   0,  3, 45, MIX_TINY},
      '{20,  255, 600,  50,  1,  2, 70, MIX_TALL},
      '{4,   2,   1000, 1,   0,  0, 30, MIX_PLAIN},
      '{10,  10,  0,    99,  3,  1, 35, MIX_PLAIN},
      '{5,   5,   4095, 100, 32, 2, 40, MIX_TINY},
      '{5,   5,   4095, 255, 63, 0, 40, MIX_TINY},
      '{7,   3,   123,  37,  0,  1, 30, MIX_PLAIN}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed boxes at reset settings: usable width 640, gaps of 8
    push_box(0, 0, 0, 0, 1);              // one-box list, all zero
    push_box(1023, 1023, 1023, 1023, 0);  // widest box opens a row
    push_box(1023, 0, 0, 1023, 0);        // wraps; label wider than image
    push_box(100, 500, 300, 100, 0);      // wraps; image wider than label
    push_box(100, 3, 50, 81, 0);          // odd label excess
    push_box(100, 700, 50, 80, 0);
    push_box(100, 1, 0, 0, 0);
    push_box(100, 64, 2, 1, 0);
    push_box(600, 10, 0, 0, 0);
    push_box(0, 1023, 1023, 0, 1);        // final box flushes the row
    push_box(300, 1, 2, 3, 0);            // new list restarts at the margins
    push_box(308, 5, 7, 9, 0);            // lands exactly on the right margin
    push_box(0, 7, 1, 1022, 0);           // zero width, still past it: wraps
    push_box(512, 256, 512, 512, 1);
    drain();

    foreach (plan[p]) begin
      idle_on = (p != $size(plan) - 1) && ($urandom_range(0, 3) != 0);
      write_reg(CFG_SPACING_X, plan[p].sx);
      write_reg(CFG_SPACING_Y, plan[p].sy);
      write_reg(CFG_SCREEN_W, plan[p].scr);
      write_reg(CFG_WIDTH_PCT, plan[p].pct);
      write_reg(CFG_COLUMN_TGT, plan[p].col);
      write_reg(CFG_ALIGN_MODE, plan[p].align);
      boxes_left = 0;
      for (int i = 0; i < plan[p].count; i++) begin
        b = make_box(plan[p].mix);
        // the run closes with a complete list
        if (p == $size(plan) - 1 && i == plan[p].count - 1) b.fin = 1'b1;
        push_box(b.fw, b.fh, b.iw, b.lw, b.fin);
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
